// ===== rtl/core/ibfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibfd_pkg
// Shared types and codes of the serial receiver frame decoder: channel
// payloads, input functions, result status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ibfd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned INDEX_W = 4;

   localparam logic [VALUE_W-1:0] SUM_SEED = 16'hFFFF;

   typedef enum logic {
      FUNC_BYTE   = 1'b0,
      FUNC_RESYNC = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_HDR  = 2'd1,
      STATUS_BAD_CMD  = 2'd2,
      STATUS_BAD_CSUM = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_HEADER  = 1'b0,
      CSR_COMMAND = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type          func;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] channel_index;
      logic [VALUE_W-1:0] channel_value;
      logic               last;
   } rsp_type;

   // Frame end report from the byte side to the result sequencer.
   typedef struct packed {
      logic       start;
      status_type status;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/core/ibfd_chan_mem.sv =====
// ----------------------------------------------------------------------------
// ibfd_chan_mem
// Channel value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfd_chan_mem #(
   parameter int unsigned DEPTH  = 14,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [ibfd_pkg::VALUE_W-1:0]  wr_data,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             rd_addr,
   output logic      [ibfd_pkg::VALUE_W-1:0]  rd_data
);
   import ibfd_pkg::*;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ibfd_frame_asm.sv =====
// ----------------------------------------------------------------------------
// ibfd_frame_asm
// Byte side of the decoder: tracks the frame position, the running checksum
// and the header and command matches, writes channel pairs into the store
// and reports each frame end to the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfd_frame_asm #(
   parameter int unsigned FRAME_BYTES = 32,
   parameter int unsigned CHANNELS    = 14,
   parameter int unsigned ADDR_W      = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire ibfd_pkg::req_type             req_data,
   output logic                               req_stall,
   input  wire logic [ibfd_pkg::BYTE_W-1:0]   header_value,
   input  wire logic [ibfd_pkg::BYTE_W-1:0]   command_value,
   input  wire logic                          job_busy,
   output ibfd_pkg::job_type                  job,
   output logic                               mem_wr_en,
   output logic      [ADDR_W-1:0]             mem_wr_addr,
   output logic      [ibfd_pkg::VALUE_W-1:0]  mem_wr_data
);
   import ibfd_pkg::*;

   localparam int unsigned POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] CS_POS = POS_W'(FRAME_BYTES - 2);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] sum_ff, sum_in;
   logic               hdr_ok_ff, hdr_ok_in;
   logic               cmd_ok_ff, cmd_ok_in;
   logic [BYTE_W-1:0]  low_ff, low_in;

   logic [POS_W-1:0]   chan;
   logic               wr_slot;
   logic               accept;
   logic [VALUE_W-1:0] csum;

   // A high byte of a channel pair lands on an odd position inside the data area.
   always_comb begin
      chan    = (pos_ff - POS_W'(2)) >> 1;
      wr_slot = (pos_ff >= POS_W'(2)) && (pos_ff < CS_POS) && pos_ff[0] &&
                (32'(chan) < CHANNELS);
   end

   // The store cannot take a new frame's channels while the previous frame's
   // results are still being read out of it.
   assign req_stall = job_busy && wr_slot;
   assign accept    = req_valid && !req_stall;

   assign mem_wr_en   = accept && (req_data.func == FUNC_BYTE) && wr_slot;
   assign mem_wr_addr = ADDR_W'(chan);
   assign mem_wr_data = {req_data.rx_byte, low_ff};
   assign csum        = {req_data.rx_byte, low_ff};

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      hdr_ok_in  = hdr_ok_ff;
      cmd_ok_in  = cmd_ok_ff;
      low_in     = low_ff;
      job.start  = 1'b0;
      job.status = STATUS_OK;
      if (accept) begin
         if (req_data.func == FUNC_RESYNC) begin
            pos_in    = '0;
            sum_in    = SUM_SEED;
            hdr_ok_in = 1'b0;
            cmd_ok_in = 1'b0;
            low_in    = '0;
         end else if (pos_ff < CS_POS) begin
            sum_in = sum_ff - VALUE_W'(req_data.rx_byte);
            if (pos_ff == POS_W'(0)) begin
               hdr_ok_in = (req_data.rx_byte == header_value);
            end else if (pos_ff == POS_W'(1)) begin
               cmd_ok_in = (req_data.rx_byte == command_value);
            end else if (!pos_ff[0]) begin
               low_in = req_data.rx_byte;
            end
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == CS_POS) begin
            low_in = req_data.rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            job.start = 1'b1;
            if (!hdr_ok_ff) begin
               job.status = STATUS_BAD_HDR;
            end else if (!cmd_ok_ff) begin
               job.status = STATUS_BAD_CMD;
            end else if (csum != sum_ff) begin
               job.status = STATUS_BAD_CSUM;
            end else begin
               job.status = STATUS_OK;
            end
            pos_in    = '0;
            sum_in    = SUM_SEED;
            hdr_ok_in = 1'b0;
            cmd_ok_in = 1'b0;
            low_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= SUM_SEED;
         hdr_ok_ff <= 1'b0;
         cmd_ok_ff <= 1'b0;
         low_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         hdr_ok_ff <= hdr_ok_in;
         cmd_ok_ff <= cmd_ok_in;
         low_ff    <= low_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ibfd_emit_seq.sv =====
// ----------------------------------------------------------------------------
// ibfd_emit_seq
// Result sequencer: at each frame end it walks the channel store, one read a
// cycle unless stalled, or issues a single error result into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfd_emit_seq #(
   parameter int unsigned FRAME_BYTES = 32,
   parameter int unsigned CHANNELS    = 14,
   parameter int unsigned ADDR_W      = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ibfd_pkg::job_type             job,
   output logic                               job_busy,
   output logic                               mem_rd_en,
   output logic      [ADDR_W-1:0]             mem_rd_addr,
   input  wire logic [ibfd_pkg::VALUE_W-1:0]  mem_rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ibfd_pkg::rsp_type                  rsp_data
);
   import ibfd_pkg::*;

   // Channels whose byte pair lies wholly inside the data area.
   localparam int unsigned DATA_CHANNELS = (FRAME_BYTES - 4) / 2;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CHANNELS - 1);

   logic              act_ff, act_in;
   status_type        jst_ff, jst_in;
   logic [ADDR_W-1:0] jidx_ff, jidx_in;

   logic              s1_vld_ff, s1_vld_in;
   status_type        s1_st_ff, s1_st_in;
   logic [ADDR_W-1:0] s1_idx_ff, s1_idx_in;
   logic              s1_last_ff, s1_last_in;
   logic              s1_zero_ff, s1_zero_in;

   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff, out_in;

   logic              issue;
   logic              out_load;
   logic              job_last;

   assign out_load = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign issue    = act_ff && (!s1_vld_ff || out_load);
   assign job_last = (jst_ff != STATUS_OK) || (jidx_ff == LAST_IDX);

   // The store's read data only moves when a new read is issued, so it holds
   // while the first stage waits on a stalled result register.
   assign mem_rd_en   = issue;
   assign mem_rd_addr = jidx_ff;
   assign job_busy    = act_ff;

   always_comb begin
      act_in  = act_ff;
      jst_in  = jst_ff;
      jidx_in = jidx_ff;
      if (job.start) begin
         act_in  = 1'b1;
         jst_in  = job.status;
         jidx_in = '0;
      end else if (issue) begin
         if (job_last) begin
            act_in = 1'b0;
         end else begin
            jidx_in = jidx_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      s1_st_in   = s1_st_ff;
      s1_idx_in  = s1_idx_ff;
      s1_last_in = s1_last_ff;
      s1_zero_in = s1_zero_ff;
      if (issue) begin
         s1_vld_in  = 1'b1;
         s1_st_in   = jst_ff;
         s1_last_in = job_last;
         if (jst_ff == STATUS_OK) begin
            s1_idx_in  = jidx_ff;
            s1_zero_in = (32'(jidx_ff) >= DATA_CHANNELS);
         end else begin
            s1_idx_in  = '0;
            s1_zero_in = 1'b1;
         end
      end else if (out_load) begin
         s1_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (out_load) begin
         out_vld_in           = 1'b1;
         out_in.status        = s1_st_ff;
         out_in.channel_index = INDEX_W'(s1_idx_ff);
         out_in.channel_value = s1_zero_ff ? '0 : mem_rd_data;
         out_in.last          = s1_last_ff;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 1'b0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         act_ff     <= act_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      jst_ff     <= jst_in;
      jidx_ff    <= jidx_in;
      s1_st_ff   <= s1_st_in;
      s1_idx_ff  <= s1_idx_in;
      s1_last_ff <= s1_last_in;
      s1_zero_ff <= s1_zero_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ibus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ibus_frame_decoder
// Assembles fixed-length receiver frames from serial bytes and reports every
// channel value, or one error result, at each frame end.
//
// Usage: each req transfer carries one received byte, or a resync that drops
// any partial frame. Bytes are taken one per cycle while req_stall is low. The byte that ends a
// frame starts the result walk: CHANNELS rsp transfers with status ok, the
// last one flagged, or a single error result (bad header, bad command or bad
// checksum, in that order). The first result passes from the final byte's
// transfer through the job, first-stage and result registers, and the rest
// follow one per cycle, paced by the one read port of the channel store.
// Bytes of the next frame keep flowing during the walk; only a byte that would
// overwrite a stored channel waits (req_stall) until the walk ends. A stalled
// rsp_stall holds the current result and, through it, the walk. Reset empties
// the result path, restarts the frame at byte zero and loads the standard
// header and command values; csr writes change them for bytes that follow.
// ----------------------------------------------------------------------------
`default_nettype none

module ibus_frame_decoder #(
   parameter int unsigned FRAME_BYTES = 32,
   parameter int unsigned CHANNELS    = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ibfd_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ibfd_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire ibfd_pkg::csr_index_type       csr_index,
   input  wire logic [ibfd_pkg::BYTE_W-1:0]   csr_wdata
);
   import ibfd_pkg::*;

   localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [BYTE_W-1:0]  hdr_ff, hdr_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;

   job_type            job;
   logic               job_busy;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   always_comb begin
      hdr_in = hdr_ff;
      cmd_in = cmd_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER:  hdr_in = csr_wdata;
            CSR_COMMAND: cmd_in = csr_wdata;
            default:     hdr_in = hdr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= 8'h20;
         cmd_ff <= 8'h40;
      end else begin
         hdr_ff <= hdr_in;
         cmd_ff <= cmd_in;
      end
   end

   ibfd_frame_asm #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS),
      .ADDR_W      (ADDR_W)
   ) u_asm (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .header_value  (hdr_ff),
      .command_value (cmd_ff),
      .job_busy      (job_busy),
      .job           (job),
      .mem_wr_en     (wr_en),
      .mem_wr_addr   (wr_addr),
      .mem_wr_data   (wr_data)
   );

   ibfd_chan_mem #(
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ibfd_emit_seq #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS),
      .ADDR_W      (ADDR_W)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .job_busy    (job_busy),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame decoder testbench
// Feeds serial bytes and resyncs into the decoder, predicts the channel and
// error reports of every frame, and checks each rsp transfer against them.
// Both handshakes idle at random; header and command values change between
// phases while the decoder is idle.
// ----------------------------------------------------------------------------

module testbench;

   import ibfd_pkg::*;

   localparam int FRAME_BYTES  = 32;
   localparam int CHANNELS     = 14;
   localparam int CSUM_POS     = FRAME_BYTES - 2;
   localparam int SETTLE_TICKS = 24;
   localparam int CYCLE_LIMIT  = 400000;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_HEADER;
   logic [7:0]    csr_wdata = '0;

   req_type rx_queue[$];
   rsp_type channel_reports[$];

   // Decoder image: registers and frame assembly state.
   logic [7:0]  header_cfg  = 8'd32;
   logic [7:0]  command_cfg = 8'd64;
   int          frame_pos;
   logic [15:0] sum_left;
   logic        header_ok;
   logic        command_ok;
   logic [7:0]  low_hold;
   logic [15:0] channel_image [CHANNELS];

   logic [15:0] chan_fill [CHANNELS];
   logic        calm       = 1'b0;
   int          fail_count = 0;
   int          cycle_count = 0;
   rsp_type     want;

   ibus_frame_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_frame();
      frame_pos  = 0;
      sum_left   = 16'hFFFF;
      header_ok  = 1'b0;
      command_ok = 1'b0;
      low_hold   = '0;
      for (int i = 0; i < CHANNELS; i++) channel_image[i] = '0;
   endfunction

   // Advances the frame image by one accepted transfer and queues the reports
   // that a completed frame produces.
   function automatic void decode_byte(req_type item);
      logic [7:0]  b;
      logic [15:0] csum;
      status_type  verdict;
      int          ch;
      b = item.rx_byte;
      if (item.func == FUNC_RESYNC) begin
         clear_frame();
         return;
      end
      if (frame_pos < CSUM_POS) begin
         sum_left = sum_left - {8'h00, b};
         if (frame_pos == 0) begin
            header_ok = (b == header_cfg);
         end else if (frame_pos == 1) begin
            command_ok = (b == command_cfg);
         end else if (((frame_pos - 2) % 2) == 0) begin
            low_hold = b;
         end else begin
            ch = (frame_pos - 2) / 2;
            if (ch < CHANNELS) channel_image[ch] = {b, low_hold};
         end
         frame_pos++;
      end else if (frame_pos == CSUM_POS) begin
         low_hold = b;
         frame_pos++;
      end else begin
         csum = {b, low_hold};
         if (!header_ok) verdict = STATUS_BAD_HDR;
         else if (!command_ok) verdict = STATUS_BAD_CMD;
         else if (csum != sum_left) verdict = STATUS_BAD_CSUM;
         else verdict = STATUS_OK;
         if (verdict != STATUS_OK) begin
            channel_reports.push_back('{status: verdict, channel_index: '0,
                                        channel_value: '0, last: 1'b1});
         end else begin
            for (int i = 0; i < CHANNELS; i++) begin
               channel_reports.push_back('{status: STATUS_OK, channel_index: 4'(i),
                                           channel_value: channel_image[i],
                                           last: (i == CHANNELS - 1)});
            end
         end
         clear_frame();
      end
   endfunction

   function automatic logic idle_roll();
      return !calm && ($urandom_range(99) < 35);
   endfunction

   // Sender: a new item is offered once the previous transfer is done.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (rx_queue.size() != 0 && !idle_roll()) begin
               req_data  <= rx_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls and a field-by-field check of each result.
   always @(posedge clock) begin
      rsp_stall <= idle_roll();
      if (!reset && rsp_valid && !rsp_stall) begin
         if (channel_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("ERROR: unexpected result status %0d index %0d value %h last %b",
                        rsp_data.status, rsp_data.channel_index,
                        rsp_data.channel_value, rsp_data.last);
         end else begin
            want = channel_reports.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.channel_index !== want.channel_index ||
                rsp_data.channel_value !== want.channel_value ||
                rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: expected status %0d index %0d value %h last %b, got %0d %0d %h %b",
                           want.status, want.channel_index, want.channel_value,
                           want.last, rsp_data.status, rsp_data.channel_index,
                           rsp_data.channel_value, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void push_byte(logic [7:0] b);
      rx_queue.push_back('{func: FUNC_BYTE, rx_byte: b});
   endfunction

   // The byte carried by a resync is ignored, so it is random.
   function automatic void push_resync();
      rx_queue.push_back('{func: FUNC_RESYNC, rx_byte: 8'($urandom)});
   endfunction

   // Queues the first keep bytes of a frame built from chan_fill; a nonzero
   // csum_flip corrupts the checksum.
   function automatic void push_frame(logic [7:0] hdr, logic [7:0] cmd,
                                      logic [15:0] csum_flip, int keep);
      logic [7:0]  frame [FRAME_BYTES];
      logic [15:0] csum;
      int          ch;
      frame[0] = hdr;
      frame[1] = cmd;
      for (int i = 2; i < CSUM_POS; i++) begin
         ch = (i - 2) / 2;
         if (ch >= CHANNELS) frame[i] = 8'($urandom);
         else if (((i - 2) % 2) == 0) frame[i] = chan_fill[ch][7:0];
         else frame[i] = chan_fill[ch][15:8];
      end
      csum = 16'hFFFF;
      for (int i = 0; i < CSUM_POS; i++) csum = csum - {8'h00, frame[i]};
      csum = csum ^ csum_flip;
      frame[CSUM_POS]     = csum[7:0];
      frame[CSUM_POS + 1] = csum[15:8];
      for (int i = 0; i < keep; i++) push_byte(frame[i]);
   endfunction

   function automatic void fill_channels();
      int r;
      for (int i = 0; i < CHANNELS; i++) begin
         r = $urandom_range(99);
         if (r < 10) chan_fill[i] = 16'h0000;
         else if (r < 20) chan_fill[i] = 16'hFFFF;
         else chan_fill[i] = 16'($urandom);
      end
   endfunction

   function automatic logic [7:0] other_than(logic [7:0] v);
      return v ^ 8'($urandom_range(255, 1));
   endfunction

   // Waits until the decoder has delivered everything queued.
   task automatic drain();
      while (rx_queue.size() != 0 || req_valid || channel_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HEADER) header_cfg = value;
      else command_cfg = value;
   endtask

   initial begin
      clear_frame();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset header and command values.
      push_resync();
      chan_fill = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00,
                    16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h0100, 16'h00FE,
                    16'hFFFF, 16'h0000};
      push_frame(header_cfg, command_cfg, '0, FRAME_BYTES);
      // Command priority over a checksum error.
      push_frame(header_cfg, other_than(command_cfg), 16'h0100, FRAME_BYTES);
      // A checksum error on its own.
      fill_channels();
      push_frame(header_cfg, command_cfg, 16'h8000, FRAME_BYTES);
      // A resync in mid-frame.
      push_frame(header_cfg, command_cfg, '0, 5);
      push_resync();
      drain();

      // One stretch with no idling on either side, under new register values.
      csr_write(CSR_HEADER, 8'hFF);
      csr_write(CSR_COMMAND, 8'h00);
      calm = 1'b1;
      fill_channels();
      // The old header value must now be rejected, ahead of the other errors.
      push_frame(8'd32, other_than(command_cfg), 16'h00FF, FRAME_BYTES);
      push_frame(header_cfg, command_cfg, '0, FRAME_BYTES);
      drain();
      calm = 1'b0;

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
